### src/register_mapped_multiply_divide_unit_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multiply/divide unit
// Same-cycle and next-cycle implication checks on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef REGISTER_MAPPED_MULTIPLY_DIVIDE_UNIT_CORE_ASSERT_SVH
`define REGISTER_MAPPED_MULTIPLY_DIVIDE_UNIT_CORE_ASSERT_SVH

// cond must hold in the same cycle as trig
`define RMMD_ASSERT_NOW(name, trig, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("rmmd assertion failed");

// cond must hold in the cycle after trig
`define RMMD_ASSERT_NEXT(name, trig, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("rmmd assertion failed");

`endif

### src/rmmd_pkg.sv
// ----------------------------------------------------------------------------
// rmmd_pkg
// Register offsets, widths and constants of the multiply/divide unit.
// ----------------------------------------------------------------------------
package rmmd_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [15:0] word_t;

	// request kinds
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_READ  = 1'b1;

	// register offsets within the page
	localparam byte_t OFS_MUL_A   = 8'h02;
	localparam byte_t OFS_MUL_B   = 8'h03;
	localparam byte_t OFS_DIVD_LO = 8'h04;
	localparam byte_t OFS_DIVD_HI = 8'h05;
	localparam byte_t OFS_DIVISOR = 8'h06;
	localparam byte_t OFS_QUOT_LO = 8'h14;
	localparam byte_t OFS_QUOT_HI = 8'h15;
	localparam byte_t OFS_RES_LO  = 8'h16;
	localparam byte_t OFS_RES_HI  = 8'h17;

	localparam word_t DIV0_QUOT = 16'hFFFF;

	// iterations of the shared adder
	localparam int MUL_STEPS = 8;
	localparam int DIV_STEPS = 16;

	typedef logic [3:0] step_t;

endpackage

### src/register_mapped_multiply_divide_unit_core.sv
// ----------------------------------------------------------------------------
// register_mapped_multiply_divide_unit_core
// Byte-mapped unsigned 8x8 multiplier and 16/8 divider with one shared adder.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall) carries one bus access: mode
//   (0 write, 1 read), register_offset and write_data. Response channel
//   (rsp_valid / rsp_stall) returns one read_data byte per request, zero for
//   writes and for reads of any offset other than the quotient and result bytes.
// Operation:
//   The response is registered and shows in the cycle after the request
//   is taken. A write to the B operand runs a shift-add multiply through
//   the shared 9-bit adder; a write to the divisor runs a restoring divide
//   through the same adder (divide by zero finishes at once). req_stall
//   stays high while the adder is busy, so no new request is taken until
//   the operation is done.
// Reset:
//   All operand and result registers clear to zero; no response pending.
// Stall:
//   While rsp_stall holds a pending response, the response register keeps
//   its byte and req_stall is raised; no request is lost.
// ----------------------------------------------------------------------------
`include "register_mapped_multiply_divide_unit_core_assert.svh"

module register_mapped_multiply_divide_unit_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  logic           mode,
	input  rmmd_pkg::byte_t register_offset,
	input  rmmd_pkg::byte_t write_data,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output rmmd_pkg::byte_t read_data
);
	import rmmd_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV} state_t;

	localparam step_t MUL_LAST = step_t'(MUL_STEPS - 1);
	localparam step_t DIV_LAST = step_t'(DIV_STEPS - 1);

	state_t state_q;
	step_t  count_q;
	byte_t  mul_a_q;
	byte_t  mul_b_q;
	word_t  dividend_q;
	byte_t  divisor_q;
	word_t  quotient_q;
	word_t  por_q;
	byte_t  hi_q;
	word_t  lo_q;
	logic   rsp_valid_q;
	byte_t  read_data_q;

	logic       accept;
	logic [8:0] alu_a;
	logic [8:0] alu_b;
	logic [9:0] alu_res;
	logic       borrow;
	byte_t      mul_hi_next;
	byte_t      mul_lo_next;
	byte_t      div_hi_next;
	word_t      div_lo_next;
	byte_t      rd_byte;

	assign req_stall = (state_q != ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign read_data = read_data_q;

	// shared adder: add for multiply, subtract for divide
	always_comb begin
		if (state_q == ST_DIV) begin
			alu_a   = {hi_q, lo_q[15]};
			alu_b   = {1'b0, divisor_q};
			alu_res = {1'b0, alu_a} - {1'b0, alu_b};
		end else begin
			alu_a   = {1'b0, hi_q};
			alu_b   = lo_q[0] ? {1'b0, mul_a_q} : 9'd0;
			alu_res = {1'b0, alu_a} + {1'b0, alu_b};
		end
	end

	assign borrow      = alu_res[9];
	assign mul_hi_next = alu_res[8:1];
	assign mul_lo_next = {alu_res[0], lo_q[7:1]};
	// partial remainder always fits 8 bits after the restore decision
	assign div_hi_next = borrow ? alu_a[7:0] : alu_res[7:0];
	assign div_lo_next = {lo_q[14:0], !borrow};

	always_comb begin
		unique case (register_offset)
			OFS_QUOT_LO: rd_byte = quotient_q[7:0];
			OFS_QUOT_HI: rd_byte = quotient_q[15:8];
			OFS_RES_LO:  rd_byte = por_q[7:0];
			OFS_RES_HI:  rd_byte = por_q[15:8];
			default:     rd_byte = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			mul_a_q     <= '0;
			mul_b_q     <= '0;
			dividend_q  <= '0;
			divisor_q   <= '0;
			quotient_q  <= '0;
			por_q       <= '0;
			hi_q        <= '0;
			lo_q        <= '0;
			rsp_valid_q <= 1'b0;
			read_data_q <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rsp_valid_q <= 1'b1;
						read_data_q <= (mode == MODE_READ) ? rd_byte : '0;
						count_q     <= '0;
						if (mode == MODE_WRITE) begin
							unique case (register_offset)
								OFS_MUL_A: mul_a_q <= write_data;
								OFS_MUL_B: begin
									mul_b_q <= write_data;
									hi_q    <= '0;
									lo_q    <= {8'd0, write_data};
									state_q <= ST_MUL;
								end
								OFS_DIVD_LO: dividend_q[7:0]  <= write_data;
								OFS_DIVD_HI: dividend_q[15:8] <= write_data;
								OFS_DIVISOR: begin
									divisor_q <= write_data;
									if (write_data == '0) begin
										quotient_q <= DIV0_QUOT;
										por_q      <= dividend_q;
									end else begin
										hi_q    <= '0;
										lo_q    <= dividend_q;
										state_q <= ST_DIV;
									end
								end
								default: ;
							endcase
						end
					end
				end
				ST_MUL: begin
					hi_q      <= mul_hi_next;
					lo_q[7:0] <= mul_lo_next;
					count_q   <= count_q + 4'd1;
					if (count_q == MUL_LAST) begin
						por_q   <= {mul_hi_next, mul_lo_next};
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					hi_q    <= div_hi_next;
					lo_q    <= div_lo_next;
					count_q <= count_q + 4'd1;
					if (count_q == DIV_LAST) begin
						quotient_q <= div_lo_next;
						por_q      <= {8'd0, div_hi_next};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// B operand register is the multiply seed; keep it consistent with the work register
	`RMMD_ASSERT_NOW(a_busy_stalls, state_q != ST_IDLE, req_stall)
	`RMMD_ASSERT_NEXT(a_mul_starts, accept && mode == MODE_WRITE && register_offset == OFS_MUL_B, state_q == ST_MUL && lo_q[7:0] == mul_b_q)
	`RMMD_ASSERT_NEXT(a_accept_responds, accept, rsp_valid_q)
	`RMMD_ASSERT_NOW(a_mul_count_range, state_q == ST_MUL, !count_q[3])

endmodule
